// File: rtl/core/mzc_pkg.sv
// ----------------------------------------------------------------------------
// Mesh Z correction package
// Shared types and constants of the mesh Z correction lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mzc_pkg;

  // Default sizes of the stores and of the coordinates.
  localparam int MaxFacesDef    = 256;
  localparam int MaxVerticesDef = 256;
  localparam int CoordWidthDef  = 32;

  // Configuration port widths.
  localparam int ApbAddrWidth = 3;
  localparam int ApbDataWidth = 32;

  // Register indexes, taken from byte address bit 2.
  localparam logic RegEnable    = 1'b0;
  localparam logic RegFaceCount = 1'b1;

  // Request codes at the input.
  localparam logic [1:0] ReqWriteVertex = 2'd0;
  localparam logic [1:0] ReqWriteFace   = 2'd1;
  localparam logic [1:0] ReqQuery       = 2'd2;

  // Determinant threshold, 0.00001 in Q.32, rounded down.
  localparam int EpsRaw = 42949;

  // Command kinds handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_VTX_WR,
    CMD_FACE_WR,
    CMD_QUERY
  } cmd_e;

  // Control part of one queued command.
  typedef struct packed {
    cmd_e       kind;
    logic [7:0] slot;
    logic [7:0] corner_a;
    logic [7:0] corner_b;
    logic [7:0] corner_c;
    logic       reverse;
  } cmd_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic       enable;
    logic [8:0] face_count;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/mzc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mzc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/mzc_front.sv
// ----------------------------------------------------------------------------
// Mesh Z correction front end
// Holds the configuration registers, classifies incoming requests and queues
// them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mzc_front import mzc_pkg::*; #(
  parameter int MAX_FACES    = MaxFacesDef,
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int COORD_WIDTH  = CoordWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [ApbDataWidth-1:0] pwdata,
  output logic      [ApbDataWidth-1:0] prdata,
  output logic                         pready,
  // Request side
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              req_type_i,
  input  wire logic [7:0]              entry_index_i,
  input  wire logic [COORD_WIDTH-1:0]  coord_x_i,
  input  wire logic [COORD_WIDTH-1:0]  coord_y_i,
  input  wire logic [COORD_WIDTH-1:0]  coord_z_i,
  input  wire logic [7:0]              corner_a_i,
  input  wire logic [7:0]              corner_b_i,
  input  wire logic [7:0]              corner_c_i,
  input  wire logic                    reverse_i,
  // Back end side
  output cfg_t                         cfg_o,
  output logic                         cmd_valid_o,
  input  wire logic                    cmd_ready_i,
  output cmd_t                         cmd_o,
  output logic      [COORD_WIDTH-1:0]  cmd_x_o,
  output logic      [COORD_WIDTH-1:0]  cmd_y_o,
  output logic      [COORD_WIDTH-1:0]  cmd_z_o
);

  localparam int QDepth = 2;

  logic       enable_q;
  logic [8:0] face_count_q;
  logic       cfg_wr;

  cmd_t                   queue_cmd_q [QDepth];
  logic [COORD_WIDTH-1:0] queue_x_q   [QDepth];
  logic [COORD_WIDTH-1:0] queue_y_q   [QDepth];
  logic [COORD_WIDTH-1:0] queue_z_q   [QDepth];
  logic                   wr_ptr_q;
  logic                   rd_ptr_q;
  logic [1:0]             count_q;
  logic                   push;
  logic                   pop;
  cmd_t                   cmd_new;

  // Register write and read.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      face_count_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegEnable:    enable_q     <= pwdata[0];
        RegFaceCount: face_count_q <= pwdata[8:0];
        default:      enable_q     <= enable_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegEnable:    prdata = {{(ApbDataWidth-1){1'b0}}, enable_q};
      RegFaceCount: prdata = {{(ApbDataWidth-9){1'b0}}, face_count_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.enable     = enable_q;
  assign cfg_o.face_count = face_count_q;

  // Classify the request; writes to slots beyond the stores become no-ops.
  always_comb begin
    cmd_new.slot     = entry_index_i;
    cmd_new.corner_a = corner_a_i;
    cmd_new.corner_b = corner_b_i;
    cmd_new.corner_c = corner_c_i;
    cmd_new.reverse  = reverse_i;
    unique case (req_type_i)
      ReqWriteVertex:
        cmd_new.kind = (int'(entry_index_i) < MAX_VERTICES) ? CMD_VTX_WR : CMD_NOP;
      ReqWriteFace:
        cmd_new.kind = (int'(entry_index_i) < MAX_FACES) ? CMD_FACE_WR : CMD_NOP;
      ReqQuery:
        cmd_new.kind = CMD_QUERY;
      default:
        cmd_new.kind = CMD_NOP;
    endcase
  end

  // Two-entry command queue between the front and the back.
  assign busy        = (count_q == 2'(QDepth));
  assign push        = start && !busy;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_cmd_q[wr_ptr_q] <= cmd_new;
      queue_x_q[wr_ptr_q]   <= coord_x_i;
      queue_y_q[wr_ptr_q]   <= coord_y_i;
      queue_z_q[wr_ptr_q]   <= coord_z_i;
    end
  end

  assign cmd_o   = queue_cmd_q[rd_ptr_q];
  assign cmd_x_o = queue_x_q[rd_ptr_q];
  assign cmd_y_o = queue_y_q[rd_ptr_q];
  assign cmd_z_o = queue_z_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: rtl/core/mzc_div.sv
// ----------------------------------------------------------------------------
// Mesh Z correction divider
// Restoring divider, one quotient bit per cycle, quotient capped at the top
// quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mzc_div #(
  parameter int NumWidth = 102,
  parameter int DenWidth = 67,
  parameter int QuoWidth = 33
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [NumWidth-1:0] num_i,
  input  wire logic [DenWidth-1:0] den_i,
  output logic                     done_o,
  output logic      [QuoWidth-1:0] quo_o
);

  localparam int CntWidth = $clog2(QuoWidth + 1);
  localparam logic [QuoWidth-1:0] QuoCap = QuoWidth'(1) << (QuoWidth - 1);

  logic                busy_q;
  logic                done_q;
  logic [CntWidth-1:0] cnt_q;
  logic [NumWidth-1:0] rem_q;
  logic [NumWidth-1:0] dsh_q;
  logic [QuoWidth-1:0] quo_q;
  logic [NumWidth-1:0] den_ext;
  logic                fits;

  assign den_ext = NumWidth'(den_i);
  assign fits    = (rem_q >= dsh_q);

  // Overflow check at start, then one trial subtraction per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (num_i >= (den_ext << QuoWidth)) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CntWidth'(QuoWidth);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntWidth'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= den_ext << (QuoWidth - 1);
      quo_q <= QuoCap;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QuoWidth-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = (quo_q > QuoCap) ? QuoCap : quo_q;

endmodule

`default_nettype wire

// File: rtl/core/mzc_back.sv
// ----------------------------------------------------------------------------
// Mesh Z correction back end
// Owns the vertex and face stores, walks the faces for a query with a shared
// multiply-accumulate unit and produces one result per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mzc_back import mzc_pkg::*; #(
  parameter int MAX_FACES    = MaxFacesDef,
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int COORD_WIDTH  = CoordWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   cmd_valid_i,
  output logic                        cmd_ready_o,
  input  wire cmd_t                   cmd_i,
  input  wire logic [COORD_WIDTH-1:0] cmd_x_i,
  input  wire logic [COORD_WIDTH-1:0] cmd_y_i,
  input  wire logic [COORD_WIDTH-1:0] cmd_z_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic      [7:0]             hit_face_o,
  output logic      [COORD_WIDTH-1:0] delta_z_o,
  output logic      [COORD_WIDTH-1:0] z_out_o
);

  localparam int W   = COORD_WIDTH;
  localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int FAW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int FCW = $clog2(MAX_FACES + 1);
  localparam int NCW = (FCW > 9) ? FCW : 9;
  localparam int EW  = W + 1;        // edge and offset width
  localparam int BW  = W + 3;        // second multiplier operand width
  localparam int PW  = EW + BW;      // product width
  localparam int MW  = 2 * W + 3;    // determinant and numerator width
  localparam int AW  = 3 * W + 6;    // accumulator width
  localparam int QW  = W + 1;        // quotient width
  localparam int NumOps = 16;
  localparam logic [W-1:0] CoordMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CoordMin = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_FACE, S_V0, S_V1, S_V2, S_V3, S_CALC, S_NORM, S_TEST, S_DIV
  } state_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_A, DST_NU, DST_NV, DST_Q0, DST_Q1, DST_NT
  } dst_e;

  typedef struct packed {
    logic vld;
    logic first;
    logic neg;
    logic shift;
    dst_e dst;
  } mac_ctl_t;

  state_e state_q;

  // Command and query registers.
  logic [W-1:0]   x_q, y_q, z_q;
  logic           rev_q;
  logic [FCW-1:0] f_q, n_q;
  logic [NCW-1:0] fc_ext;
  logic [FCW-1:0] n_lim;
  logic [7:0]     corner_b_q, corner_c_q;
  logic [5:0]     k_q;
  logic           pop;

  // Stores.
  logic           vram_we, fram_we;
  logic [VAW-1:0] vram_raddr;
  logic [3*W-1:0] vram_rdata;
  logic [23:0]    fram_rdata;
  logic [7:0]     corner_sel;
  logic           corner_ok, vok_q;
  logic [W-1:0]   vx, vy, vz;

  // Geometry registers.
  logic signed [W-1:0]  p0x_q, p0y_q, p0z_q;
  logic signed [EW-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q, sx_q, sy_q, sz_q;
  logic signed [MW-1:0] a_q, nu_q, nv_q, q0_q, q1_q;
  logic signed [AW-1:0] nt_q, acc_q, acc_d, term;
  logic signed [EW-1:0] opa;
  logic signed [BW-1:0] opb;
  logic signed [PW-1:0] prod_q;
  mac_ctl_t             op_ctl, mac_q;
  logic                 nt_neg_q;

  // Face test and result shaping.
  logic signed [MW:0]   uv_sum;
  logic                 skip;
  logic [AW-1:0]        nt_mag;
  logic                 div_start, div_done;
  logic [QW-1:0]        div_quo, quo_neg;
  logic [W-1:0]         t_val;
  logic signed [W:0]    z_sum;
  logic [W-1:0]         z_sat;
  logic [FCW-1:0]       f_next;

  // Store ports: writes are taken straight from the command being popped.
  assign cmd_ready_o = (state_q == S_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign vram_we     = pop && (cmd_i.kind == CMD_VTX_WR);
  assign fram_we     = pop && (cmd_i.kind == CMD_FACE_WR);

  always_comb begin
    unique case (state_q)
      S_V0:    corner_sel = fram_rdata[7:0];
      S_V1:    corner_sel = corner_b_q;
      default: corner_sel = corner_c_q;
    endcase
  end

  assign corner_ok  = (int'(corner_sel) < MAX_VERTICES);
  assign vram_raddr = VAW'(corner_sel);

  mzc_ram #(
    .Width (3 * W),
    .Depth (MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (VAW'(cmd_i.slot)),
    .wdata_i ({cmd_z_i, cmd_y_i, cmd_x_i}),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  mzc_ram #(
    .Width (24),
    .Depth (MAX_FACES)
  ) u_face_ram (
    .clk_i   (clk_i),
    .we_i    (fram_we),
    .waddr_i (FAW'(cmd_i.slot)),
    .wdata_i ({cmd_i.corner_c, cmd_i.corner_b, cmd_i.corner_a}),
    .raddr_i (f_q[FAW-1:0]),
    .rdata_o (fram_rdata)
  );

  // A corner beyond the vertex store reads as the origin.
  assign vx = vok_q ? vram_rdata[W-1:0]     : '0;
  assign vy = vok_q ? vram_rdata[2*W-1:W]   : '0;
  assign vz = vok_q ? vram_rdata[3*W-1:2*W] : '0;

  // Number of faces searched, limited to the store depth.
  assign fc_ext = NCW'(cfg_i.face_count);
  assign n_lim  = (fc_ext > NCW'(MAX_FACES)) ? FCW'(MAX_FACES) : FCW'(fc_ext);

  // Operand schedule of the multiply-accumulate unit.
  always_comb begin
    opa    = e1y_q;
    opb    = BW'(e2x_q);
    op_ctl = '{vld: 1'b0, first: 1'b0, neg: 1'b0, shift: 1'b0, dst: DST_NONE};
    op_ctl.vld = (state_q == S_CALC) && (k_q < 6'(NumOps));
    unique case (k_q[3:0])
      4'd0: begin
        opa = e1y_q; opb = BW'(e2x_q); op_ctl.first = 1'b1;
      end
      4'd1: begin
        opa = e1x_q; opb = BW'(e2y_q); op_ctl.neg = 1'b1; op_ctl.dst = DST_A;
      end
      4'd2: begin
        opa = sy_q; opb = BW'(e2x_q); op_ctl.first = 1'b1;
      end
      4'd3: begin
        opa = sx_q; opb = BW'(e2y_q); op_ctl.neg = 1'b1; op_ctl.dst = DST_NU;
      end
      4'd4: begin
        opa = sx_q; opb = BW'(e1y_q); op_ctl.first = 1'b1;
      end
      4'd5: begin
        opa = e1x_q; opb = BW'(sy_q); op_ctl.neg = 1'b1; op_ctl.dst = DST_NV;
      end
      4'd6: begin
        opa = sy_q; opb = BW'(e1z_q); op_ctl.first = 1'b1;
      end
      4'd7: begin
        opa = e1y_q; opb = BW'(sz_q); op_ctl.neg = 1'b1; op_ctl.dst = DST_Q0;
      end
      4'd8: begin
        opa = sz_q; opb = BW'(e1x_q); op_ctl.first = 1'b1;
      end
      4'd9: begin
        opa = e1z_q; opb = BW'(sx_q); op_ctl.neg = 1'b1; op_ctl.dst = DST_Q1;
      end
      4'd10: begin
        opa = e2x_q; opb = {3'b000, q0_q[W-1:0]}; op_ctl.first = 1'b1;
      end
      4'd11: begin
        opa = e2x_q; opb = q0_q[MW-1:W]; op_ctl.shift = 1'b1;
      end
      4'd12: begin
        opa = e2y_q; opb = {3'b000, q1_q[W-1:0]};
      end
      4'd13: begin
        opa = e2y_q; opb = q1_q[MW-1:W]; op_ctl.shift = 1'b1;
      end
      4'd14: begin
        opa = e2z_q; opb = {3'b000, nv_q[W-1:0]};
      end
      4'd15: begin
        opa = e2z_q; opb = nv_q[MW-1:W]; op_ctl.shift = 1'b1; op_ctl.dst = DST_NT;
      end
      default: begin
        opa = e1y_q;
      end
    endcase
  end

  // Accumulate stage, one product behind the multiplier.
  always_comb begin
    term  = AW'(prod_q);
    if (mac_q.shift) begin
      term = term <<< W;
    end
    acc_d = (mac_q.first ? AW'(0) : acc_q) + (mac_q.neg ? -term : term);
  end

  // Multiplier and accumulator registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= '{vld: 1'b0, first: 1'b0, neg: 1'b0, shift: 1'b0, dst: DST_NONE};
    end else begin
      mac_q <= op_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    if (mac_q.vld) begin
      acc_q <= acc_d;
      unique case (mac_q.dst)
        DST_A:   a_q  <= MW'(acc_d);
        DST_NU:  nu_q <= MW'(acc_d);
        DST_NV:  nv_q <= MW'(acc_d);
        DST_Q0:  q0_q <= MW'(acc_d);
        DST_Q1:  q1_q <= MW'(acc_d);
        DST_NT:  nt_q <= acc_d;
        default: ;
      endcase
    end else if (state_q == S_NORM && a_q[MW-1]) begin
      // Make the determinant positive; the numerators follow.
      a_q  <= -a_q;
      nu_q <= -nu_q;
      nv_q <= -nv_q;
      nt_q <= -nt_q;
    end
  end

  // Vertex fetch: edges and offsets from the first corner.
  always_ff @(posedge clk_i) begin
    vok_q <= corner_ok;
    unique case (state_q)
      S_V0: begin
        corner_b_q <= fram_rdata[15:8];
        corner_c_q <= fram_rdata[23:16];
      end
      S_V1: begin
        p0x_q <= vx;
        p0y_q <= vy;
        p0z_q <= vz;
        sz_q  <= -EW'($signed(vz));
      end
      S_V2: begin
        e1x_q <= EW'($signed(vx)) - EW'(p0x_q);
        e1y_q <= EW'($signed(vy)) - EW'(p0y_q);
        e1z_q <= EW'($signed(vz)) - EW'(p0z_q);
        sx_q  <= EW'($signed(x_q)) - EW'(p0x_q);
        sy_q  <= EW'($signed(y_q)) - EW'(p0y_q);
      end
      S_V3: begin
        e2x_q <= EW'($signed(vx)) - EW'(p0x_q);
        e2y_q <= EW'($signed(vy)) - EW'(p0y_q);
        e2z_q <= EW'($signed(vz)) - EW'(p0z_q);
      end
      default: begin
        corner_b_q <= corner_b_q;
      end
    endcase
  end

  // Inside test with borders included, and the determinant threshold.
  assign uv_sum = (MW + 1)'(nu_q) + (MW + 1)'(nv_q);
  assign skip   = (a_q <= MW'(EpsRaw)) || nu_q[MW-1] || (nu_q > a_q) ||
                  nv_q[MW-1] || (uv_sum > (MW + 1)'(a_q));
  assign nt_mag = nt_q[AW-1] ? AW'(-nt_q) : AW'(nt_q);
  assign div_start = (state_q == S_TEST) && !skip;

  mzc_div #(
    .NumWidth (AW),
    .DenWidth (MW),
    .QuoWidth (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (nt_mag),
    .den_i   (MW'(a_q)),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Height of the face, saturated to the coordinate range.
  always_comb begin
    quo_neg = -div_quo;
    if (nt_neg_q) begin
      t_val = (div_quo > (QW'(1) << (W - 1))) ? CoordMin : quo_neg[W-1:0];
    end else begin
      t_val = (div_quo > QW'(CoordMax)) ? CoordMax : div_quo[W-1:0];
    end
    if (rev_q) begin
      z_sum = (W + 1)'($signed(z_q)) - (W + 1)'($signed(t_val));
    end else begin
      z_sum = (W + 1)'($signed(z_q)) + (W + 1)'($signed(t_val));
    end
    if (z_sum[W] != z_sum[W-1]) begin
      z_sat = z_sum[W] ? CoordMin : CoordMax;
    end else begin
      z_sat = z_sum[W-1:0];
    end
  end

  assign f_next = f_q + 1'b1;

  // Sequencer with the registered result outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_o     <= 1'b0;
      hit_o      <= 1'b0;
      hit_face_o <= '0;
      delta_z_o  <= '0;
      z_out_o    <= '0;
      f_q        <= '0;
      n_q        <= '0;
      k_q        <= '0;
      nt_neg_q   <= 1'b0;
      rev_q      <= 1'b0;
    end else begin
      done_o <= 1'b0;
      hit_o  <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            x_q   <= cmd_x_i;
            y_q   <= cmd_y_i;
            z_q   <= cmd_z_i;
            rev_q <= cmd_i.reverse;
            f_q   <= '0;
            n_q   <= n_lim;
            hit_face_o <= '0;
            delta_z_o  <= '0;
            if (cmd_i.kind == CMD_QUERY) begin
              if (cfg_i.enable && (n_lim != '0)) begin
                state_q <= S_FACE;
              end else begin
                done_o  <= 1'b1;
                z_out_o <= cmd_z_i;
              end
            end else begin
              done_o  <= 1'b1;
              z_out_o <= '0;
            end
          end
        end
        S_FACE: state_q <= S_V0;
        S_V0:   state_q <= S_V1;
        S_V1:   state_q <= S_V2;
        S_V2:   state_q <= S_V3;
        S_V3: begin
          k_q     <= '0;
          state_q <= S_CALC;
        end
        S_CALC: begin
          k_q <= k_q + 1'b1;
          if (k_q == 6'(NumOps)) begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          nt_neg_q <= nt_q[AW-1] ^ a_q[MW-1];
          state_q  <= S_TEST;
        end
        S_TEST: begin
          if (!skip) begin
            state_q <= S_DIV;
          end else if (f_next == n_q) begin
            done_o     <= 1'b1;
            hit_face_o <= '0;
            delta_z_o  <= '0;
            z_out_o    <= z_q;
            state_q    <= S_IDLE;
          end else begin
            f_q     <= f_next;
            state_q <= S_FACE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            done_o     <= 1'b1;
            hit_o      <= 1'b1;
            hit_face_o <= 8'(f_q);
            delta_z_o  <= t_val;
            z_out_o    <= z_sat;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mesh_z_correction_lookup.sv
// ----------------------------------------------------------------------------
// Mesh Z correction lookup
// Stores a bed-height triangle mesh and corrects z by the height of the first
// face that covers the queried (x, y) point.
// ----------------------------------------------------------------------------
// Writes: queued, then popped by the idle back end, which registers the result;
// one write per cycle while busy is low. Queries: each face tested passes S_FACE, S_V0
// to S_V3, S_CALC, S_NORM and S_TEST; a hit adds S_DIV, cut short on quotient overflow.
// Up to two accepted transactions queue while the back end works; busy marks full.
// Results are shown for one cycle and cannot be stalled.
// Reset clears configuration and control; mesh stores are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module mesh_z_correction_lookup import mzc_pkg::*; #(
  parameter int MAX_FACES    = MaxFacesDef,
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int COORD_WIDTH  = CoordWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [ApbDataWidth-1:0] pwdata,
  output logic      [ApbDataWidth-1:0] prdata,
  output logic                         pready,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              req_type_i,
  input  wire logic [7:0]              entry_index_i,
  input  wire logic [COORD_WIDTH-1:0]  coord_x_i,
  input  wire logic [COORD_WIDTH-1:0]  coord_y_i,
  input  wire logic [COORD_WIDTH-1:0]  coord_z_i,
  input  wire logic [7:0]              corner_a_i,
  input  wire logic [7:0]              corner_b_i,
  input  wire logic [7:0]              corner_c_i,
  input  wire logic                    reverse_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic      [7:0]              hit_face_o,
  output logic      [COORD_WIDTH-1:0]  delta_z_o,
  output logic      [COORD_WIDTH-1:0]  z_out_o
);

  cfg_t                   cfg;
  logic                   cmd_valid;
  logic                   cmd_ready;
  cmd_t                   cmd;
  logic [COORD_WIDTH-1:0] cmd_x, cmd_y, cmd_z;

  // Front end: registers, classification and command queue.
  mzc_front #(
    .MAX_FACES    (MAX_FACES),
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .corner_a_i    (corner_a_i),
    .corner_b_i    (corner_b_i),
    .corner_c_i    (corner_c_i),
    .reverse_i     (reverse_i),
    .cfg_o         (cfg),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd),
    .cmd_x_o       (cmd_x),
    .cmd_y_o       (cmd_y),
    .cmd_z_o       (cmd_z)
  );

  // Back end: stores, face walk and result.
  mzc_back #(
    .MAX_FACES    (MAX_FACES),
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cmd_x_i     (cmd_x),
    .cmd_y_i     (cmd_y),
    .cmd_z_i     (cmd_z),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .hit_face_o  (hit_face_o),
    .delta_z_o   (delta_z_o),
    .z_out_o     (z_out_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/mzc_checker.sv
// ----------------------------------------------------------------------------
// Mesh Z correction checker
// Port-level assertions on the mesh Z correction lookup, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mzc_checker #(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   done_o,
  input wire logic                   hit_o,
  input wire logic [7:0]             hit_face_o,
  input wire logic [COORD_WIDTH-1:0] delta_z_o
);

  // The queue only fills through an accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted transaction");

  // A hit is only reported together with the result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> done_o)
    else $error("hit shown outside a result");

  // A result without a hit carries no face and no correction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (hit_face_o == 8'd0) && (delta_z_o == '0))
    else $error("miss result carries a face or a correction");

endmodule

bind mesh_z_correction_lookup mzc_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_mzc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .hit_o      (hit_o),
  .hit_face_o (hit_face_o),
  .delta_z_o  (delta_z_o)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Mesh Z correction lookup testbench
// Loads a bed-height mesh, then checks every correction query and write
// acknowledgement against a bit-exact predictor of the face walk. Directed
// cases cover the borders, degenerate faces, saturation and the unused
// request; random traffic follows under three sender idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mzc_pkg::*;

  localparam int          WatchdogLimit = 5000;
  localparam logic [1:0]  ReqUnused     = 2'd3;
  localparam logic [2:0]  AddrEnable    = {RegEnable, 2'b00};
  localparam logic [2:0]  AddrFaceCount = {RegFaceCount, 2'b00};
  localparam int          GridStep      = 10 << 16;
  localparam logic signed [31:0] CoordMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] CoordMin = -32'sh7fff_ffff - 1;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          slot;
    logic signed [31:0]  x;
    logic signed [31:0]  y;
    logic signed [31:0]  z;
    logic [7:0]          ca;
    logic [7:0]          cb;
    logic [7:0]          cc;
    logic                rev;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic [7:0]         face;
    logic signed [31:0] delta;
    logic signed [31:0] zout;
  } correction_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel, penable, pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;
  logic                    start, busy;
  logic [1:0]              req_type_i;
  logic [7:0]              entry_index_i;
  logic [31:0]             coord_x_i, coord_y_i, coord_z_i;
  logic [7:0]              corner_a_i, corner_b_i, corner_c_i;
  logic                    reverse_i;
  logic                    done_o, hit_o;
  logic [7:0]              hit_face_o;
  logic [31:0]             delta_z_o, z_out_o;

  // Predictor state: mesh stores and configuration.
  logic signed [31:0] mesh_vx [256];
  logic signed [31:0] mesh_vy [256];
  logic signed [31:0] mesh_vz [256];
  logic [7:0]         mesh_fc [256][3];
  logic               model_enable;
  logic [8:0]         model_face_count;

  correction_t pending_results[$];
  int          error_count;
  int          idle_pct;
  int          query_count;
  int          hit_count;
  int          stall_count;

  mesh_z_correction_lookup dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .req_type_i, .entry_index_i, .coord_x_i, .coord_y_i,
    .coord_z_i, .corner_a_i, .corner_b_i, .corner_c_i, .reverse_i,
    .done_o, .hit_o, .hit_face_o, .delta_z_o, .z_out_o
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Saturates a wide value to the signed coordinate range.
  function automatic logic signed [31:0] clamp_coord(input wide_t v);
    if (v > wide_t'(CoordMax)) return CoordMax;
    if (v < wide_t'(CoordMin)) return CoordMin;
    return v[31:0];
  endfunction

  // Intersects the vertical line through (x, y) with one face; exact arithmetic.
  function automatic logic face_height(input int f, input logic signed [31:0] x,
                                       input logic signed [31:0] y,
                                       output logic signed [31:0] height);
    wide_t p0x, p0y, p0z, e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
    wide_t det, nu, nv, q0, q1, nt;
    p0x = mesh_vx[mesh_fc[f][0]];
    p0y = mesh_vy[mesh_fc[f][0]];
    p0z = mesh_vz[mesh_fc[f][0]];
    e1x = wide_t'(mesh_vx[mesh_fc[f][1]]) - p0x;
    e1y = wide_t'(mesh_vy[mesh_fc[f][1]]) - p0y;
    e1z = wide_t'(mesh_vz[mesh_fc[f][1]]) - p0z;
    e2x = wide_t'(mesh_vx[mesh_fc[f][2]]) - p0x;
    e2y = wide_t'(mesh_vy[mesh_fc[f][2]]) - p0y;
    e2z = wide_t'(mesh_vz[mesh_fc[f][2]]) - p0z;
    sx  = wide_t'(x) - p0x;
    sy  = wide_t'(y) - p0y;
    sz  = -p0z;
    height = '0;
    det = e1y * e2x - e1x * e2y;
    if (det >= -wide_t'(EpsRaw) && det <= wide_t'(EpsRaw)) return 1'b0;
    nu = sy * e2x - sx * e2y;
    nv = sx * e1y - e1x * sy;
    q0 = sy * e1z - e1y * sz;
    q1 = sz * e1x - e1z * sx;
    nt = e2x * q0 + e2y * q1 + e2z * nv;
    if (det < 0) begin
      det = -det;
      nu  = -nu;
      nv  = -nv;
      nt  = -nt;
    end
    if (nu < 0 || nu > det) return 1'b0;
    if (nv < 0 || nu + nv > det) return 1'b0;
    height = clamp_coord(nt / det);
    return 1'b1;
  endfunction

  // Applies one request to the predictor and returns its expected result.
  function automatic correction_t predict_correction(input request_t r);
    correction_t res;
    logic signed [31:0] h;
    int n;
    res = '0;
    case (r.kind)
      ReqWriteVertex: begin
        mesh_vx[r.slot] = r.x;
        mesh_vy[r.slot] = r.y;
        mesh_vz[r.slot] = r.z;
      end
      ReqWriteFace: begin
        mesh_fc[r.slot][0] = r.ca;
        mesh_fc[r.slot][1] = r.cb;
        mesh_fc[r.slot][2] = r.cc;
      end
      ReqQuery: begin
        n = (model_face_count > 256) ? 256 : model_face_count;
        if (model_enable) begin
          for (int f = 0; f < n; f++) begin
            if (face_height(f, r.x, r.y, h)) begin
              res.hit   = 1'b1;
              res.face  = f[7:0];
              res.delta = h;
              break;
            end
          end
        end
        if (r.rev) res.zout = clamp_coord(wide_t'(r.z) - wide_t'(res.delta));
        else res.zout = clamp_coord(wide_t'(r.z) + wide_t'(res.delta));
      end
      default: ;
    endcase
    return res;
  endfunction

  // Register write over the configuration port; called only while idle.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == AddrEnable) model_enable = data[0];
    else model_face_count = data[8:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sends one transaction and records its expected result on acceptance.
  task automatic send_request(input request_t r);
    req_type_i    <= r.kind;
    entry_index_i <= r.slot;
    coord_x_i     <= r.x;
    coord_y_i     <= r.y;
    coord_z_i     <= r.z;
    corner_a_i    <= r.ca;
    corner_b_i    <= r.cb;
    corner_c_i    <= r.cc;
    reverse_i     <= r.rev;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(predict_correction(r));
    if (r.kind == ReqQuery) query_count++;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk_i);
    end
  endtask

  // Waits until every expected result has come back.
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic request_t make_vertex(input int slot, input int x, input int y,
                                           input int z);
    request_t r;
    r = '0;
    r.kind = ReqWriteVertex;
    r.slot = slot[7:0];
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic request_t make_face(input int slot, input int a, input int b,
                                         input int c);
    request_t r;
    r = '0;
    r.kind = ReqWriteFace;
    r.slot = slot[7:0];
    r.ca = a[7:0];
    r.cb = b[7:0];
    r.cc = c[7:0];
    return r;
  endfunction

  function automatic request_t make_query(input int x, input int y, input int z,
                                          input logic rev);
    request_t r;
    r = '0;
    r.kind = ReqQuery;
    r.x = x;
    r.y = y;
    r.z = z;
    r.rev = rev;
    return r;
  endfunction

  // Builds a 4 x 4 grid mesh, a degenerate face ahead of it, a high plateau and
  // spare faces 20 to 23 on mesh corners. Every face read later is written here.
  task automatic test_grid_mesh;
    int v;
    for (int i = 0; i < 16; i++)
      send_request(make_vertex(i, (i % 4) * GridStep, (i / 4) * GridStep,
                               $urandom_range(32'h0004_0000) - 32'h0002_0000));
    send_request(make_vertex(16, 100 << 16, 0, 32'h7fff_0000));
    send_request(make_vertex(17, 200 << 16, 0, 32'h7fff_0000));
    send_request(make_vertex(18, 100 << 16, 100 << 16, 32'h7fff_0000));
    // Collinear corners give a zero determinant.
    send_request(make_face(0, 0, 1, 2));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        v = r * 4 + c;
        send_request(make_face(1 + 2 * (r * 3 + c), v, v + 1, v + 4));
        send_request(make_face(2 + 2 * (r * 3 + c), v + 1, v + 5, v + 4));
      end
    end
    send_request(make_face(19, 16, 17, 18));
    for (int i = 20; i < 24; i++)
      send_request(make_face(i, $urandom_range(18), $urandom_range(18),
                             $urandom_range(18)));
    drain();
  endtask

  // Directed queries: enable off, no faces, borders, misses, saturation and
  // face counts at and above the store size.
  task automatic test_directed_queries;
    write_register(AddrEnable, 32'd0);
    write_register(AddrFaceCount, 32'd20);
    send_request(make_query(5 << 16, 5 << 16, 32'h0001_2345, 1'b0));
    drain();
    write_register(AddrEnable, 32'd1);
    write_register(AddrFaceCount, 32'd0);
    send_request(make_query(5 << 16, 5 << 16, 32'h0001_2345, 1'b1));
    drain();
    write_register(AddrFaceCount, 32'd20);
    send_request(make_query(0, 0, 0, 1'b0));
    send_request(make_query(GridStep, GridStep, 32'h0010_0000, 1'b1));
    send_request(make_query(GridStep / 2, GridStep, 0, 1'b0));
    send_request(make_query(GridStep / 2, GridStep / 2, 0, 1'b0));
    send_request(make_query(3 * GridStep, 3 * GridStep, 0, 1'b1));
    send_request(make_query(-(5 << 16), 5 << 16, 32'h0000_1000, 1'b0));
    send_request(make_query(120 << 16, 10 << 16, CoordMax, 1'b0));
    send_request(make_query(120 << 16, 10 << 16, CoordMin, 1'b1));
    send_request(make_query(CoordMin, CoordMax, CoordMin, 1'b0));
    begin
      request_t r;
      r = make_query($urandom, $urandom, $urandom, 1'b1);
      r.kind = ReqUnused;
      r.slot = 8'hff;
      r.ca = 8'hff;
      r.cb = 8'hff;
      r.cc = 8'hff;
      send_request(r);
    end
    drain();
    // A full-size count and one above the store size; the grid stops the walk.
    write_register(AddrFaceCount, 32'd256);
    send_request(make_query(GridStep + GridStep / 4, GridStep / 2, $urandom, 1'b0));
    drain();
    write_register(AddrFaceCount, 32'd511);
    send_request(make_query(2 * GridStep, 5 * GridStep / 2, $urandom, 1'b1));
    drain();
  endtask

  // Random traffic in chunks, with a fresh register setting before each chunk.
  // Large face counts only see queries inside the grid, which always hit when enabled.
  task automatic test_random_traffic(input int pct, input int chunks);
    request_t r;
    int sel;
    logic wide_walk;
    idle_pct = pct;
    for (int k = 0; k < chunks; k++) begin
      write_register(AddrEnable, {31'd0, ($urandom_range(9) != 0)});
      sel = $urandom_range(15);
      wide_walk = (sel < 2);
      if (sel == 0) write_register(AddrFaceCount, 32'd256);
      else if (sel == 1) write_register(AddrFaceCount, $urandom_range(511, 257));
      else write_register(AddrFaceCount, $urandom_range(24));
      for (int i = 0; i < 12; i++) begin
        sel = $urandom_range(99);
        if (sel < 12) begin
          r = make_vertex($urandom_range(15), 0, 0,
                          $urandom_range(32'h0010_0000) - 32'h0008_0000);
          r.x = (r.slot % 4) * GridStep;
          r.y = (r.slot / 4) * GridStep;
        end else if (sel < 16) begin
          r = make_vertex($urandom_range(255, 20), $urandom, $urandom, $urandom);
        end else if (sel < 24) begin
          r = make_face($urandom_range(23, 20), $urandom_range(18), $urandom_range(18),
                        $urandom_range(18));
        end else if (sel < 30 && !wide_walk) begin
          r = make_query($urandom, $urandom, $urandom, $urandom_range(1));
        end else if (sel < 40) begin
          r = make_query($urandom_range(3) * GridStep, $urandom_range(3) * GridStep,
                         $urandom, $urandom_range(1));
        end else begin
          r = make_query($urandom_range(3 * GridStep), $urandom_range(3 * GridStep),
                         $urandom, $urandom_range(1));
        end
        send_request(r);
      end
      drain();
    end
  endtask

  // Result checker: each strobe is compared with the oldest expectation.
  always @(posedge clk_i) begin
    correction_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no expectation, hit %0b face %0d z %h", $time,
                 hit_o, hit_face_o, z_out_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.hit) hit_count++;
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %0b, actual %0b", $time, want.hit, hit_o);
          error_count++;
        end
        if (hit_face_o !== want.face) begin
          $display("%0t: hit_face expected %0d, actual %0d", $time, want.face,
                   hit_face_o);
          error_count++;
        end
        if (delta_z_o !== want.delta) begin
          $display("%0t: delta_z expected %h, actual %h", $time, want.delta, delta_z_o);
          error_count++;
        end
        if (z_out_o !== want.zout) begin
          $display("%0t: z_out expected %h, actual %h", $time, want.zout, z_out_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction, no result and no register access.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || psel) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= WatchdogLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    error_count = 0;
    idle_pct = 0;
    query_count = 0;
    hit_count = 0;
    stall_count = 0;
    model_enable = 1'b0;
    model_face_count = '0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    req_type_i = '0;
    entry_index_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    corner_a_i = '0;
    corner_b_i = '0;
    corner_c_i = '0;
    reverse_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_grid_mesh();
    test_directed_queries();
    test_random_traffic(31, 3);
    test_random_traffic(63, 2);
    test_random_traffic(0, 2);

    drain();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d queries over a grid mesh with spare faces; %0d found a covering face.",
             query_count, hit_count);
    $display("Three sender idling profiles, register settings changed per chunk.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
